// ----- src/uhid_pkg.sv -----
package uhid_pkg;

  localparam int unsigned NumPads = 2;

  // event codes
  localparam logic [2:0] CMD_SOF   = 3'd0;
  localparam logic [2:0] CMD_SETUP = 3'd1;
  localparam logic [2:0] CMD_PAD   = 3'd2;
  localparam logic [2:0] CMD_INDONE = 3'd3;
  localparam logic [2:0] CMD_BUSRST = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_STALL  = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SOF_PRESCALE = 2'd0;
  localparam logic [1:0] REG_STRING_COUNT = 2'd1;
  localparam logic [1:0] REG_DEFAULT_IDLE = 2'd2;

  // endpoint actions
  localparam logic [2:0] EPA_NONE    = 3'd0;
  localparam logic [2:0] EPA_TOGGLE  = 3'd1;
  localparam logic [2:0] EPA_UNSTALL = 3'd2;
  localparam logic [2:0] EPA_STALL   = 3'd3;
  localparam logic [2:0] EPA_REARM   = 3'd4;

  // descriptor selects
  localparam logic [2:0] DSC_DEVICE = 3'd1;
  localparam logic [2:0] DSC_CONFIG = 3'd2;
  localparam logic [2:0] DSC_STRING = 3'd3;
  localparam logic [2:0] DSC_HID    = 3'd4;
  localparam logic [2:0] DSC_REPORT = 3'd5;

  // standard and class request codes
  localparam logic [7:0] RQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] RQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] RQ_GET_IDLE    = 8'h02;
  localparam logic [7:0] RQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] RQ_GET_DESC    = 8'h06;
  localparam logic [7:0] RQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] RQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] RQ_GET_IFACE   = 8'h0a;
  localparam logic [7:0] RQ_SET_IFACE   = 8'h0b;

  localparam logic [7:0] RT_CLASS_IN  = 8'ha1;
  localparam logic [7:0] RT_CLASS_OUT = 8'h21;

  localparam logic [7:0] DEFAULT_IDLE_RST = 8'd125;
  localparam logic [7:0] PRESCALE_RST     = 8'd4;
  localparam logic [7:0] STRING_CNT_RST   = 8'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] request_type;
    logic [7:0] request;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] index_low;
    logic       pad;
    logic [7:0] pad_byte0;
    logic [7:0] pad_byte1;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       report_pad;
    logic [1:0] length;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [2:0] descriptor;
    logic [7:0] str_idx;
    logic [2:0] ep_action;
    logic [1:0] ep_target;
    logic       last;
  } out_word_t;

  // state updates asked for by a setup decode
  typedef struct packed {
    logic       clr_pending;
    logic       idle_wr;
    logic       idle_off;
    logic [7:0] duration;
    logic       pad;
  } setup_upd_t;

endpackage

// ----- src/usb_hid_request_and_idle_reporter.sv -----
// A result word is registered and shown the cycle after its event is taken.
// Throughput: one event per cycle when not stalled; a tick that sends two reports puts out
// two words in turn, and the input stalls while the second waits in the hold register.
// The input also stalls while the output word waits on the receiver.
// Reset: asynchronous, active low; registers but the output and hold data take
// their reset values, no clearing pass.
module usb_hid_request_and_idle_reporter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  uhid_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uhid_pkg::out_word_t out_data_o
);
  import uhid_pkg::*;

  logic [7:0]  prescale_q, strcnt_q, defidle_q, sofcnt_q, sofcnt_d;
  logic [1:0]  off_q, off_d, pend_q, pend_d, busy_q, busy_d;
  logic [7:0]  dur_q [NumPads];
  logic [7:0]  dur_d [NumPads];
  logic [7:0]  icnt_q [NumPads];
  logic [7:0]  icnt_d [NumPads];
  logic [15:0] rep_q [NumPads];
  logic [15:0] rep_d [NumPads];

  logic       ovalid_q, hvalid_q, accept, ofree;
  out_word_t  odata_q, hdata_q, res0, res1, setup_res;
  logic       two;
  setup_upd_t upd;
  logic [1:0] send;

  // take a word only when the output register can load and the hold is empty
  assign ofree      = !ovalid_q || !out_stall_i;
  assign in_stall_o = hvalid_q || !ofree;
  assign accept     = in_valid_i && !in_stall_o;

  uhid_setup_dec u_dec (
    .word_i        (in_data_i),
    .string_count_i(strcnt_q),
    .report_i      (rep_q[in_data_i.index_low[0]]),
    .duration_i    (dur_q[in_data_i.index_low[0]]),
    .res_o         (setup_res),
    .upd_o         (upd)
  );

  // event processing
  always_comb begin
    logic [7:0] dec;
    logic       tick, s;
    sofcnt_d = sofcnt_q;
    off_d = off_q; pend_d = pend_q; busy_d = busy_q;
    dur_d = dur_q; icnt_d = icnt_q; rep_d = rep_q;
    send = '0;
    tick = 1'b0;
    dec = '0;
    s = 1'b0;
    res0 = '0; res0.last = 1'b1;
    res1 = '0;
    two = 1'b0;
    case (in_data_i.cmd)
      CMD_SOF: begin
        sofcnt_d = sofcnt_q - 8'd1;
        tick = (sofcnt_d == 8'd0);
        if (tick) sofcnt_d = prescale_q;
      end
      CMD_SETUP: begin
        res0 = setup_res;
        if (upd.clr_pending) pend_d[upd.pad] = 1'b0;
        if (upd.idle_wr) begin
          off_d[upd.pad] = upd.idle_off;
          if (!upd.idle_off) dur_d[upd.pad] = upd.duration;
        end
      end
      CMD_PAD: begin
        rep_d[in_data_i.pad] = {in_data_i.pad_byte1, in_data_i.pad_byte0};
        pend_d[in_data_i.pad] = 1'b1;
      end
      CMD_INDONE: busy_d[in_data_i.pad] = 1'b0;
      CMD_BUSRST: begin
        busy_d = '0; off_d = '0;
        dur_d[0] = defidle_q; dur_d[1] = defidle_q;
        sofcnt_d = prescale_q;
      end
      default: ;
    endcase
    // per-pad idle service on a prescaled tick
    if (tick) begin
      for (int p = 0; p < NumPads; p++) begin
        s = 1'b0;
        if (!off_q[p]) begin
          dec = icnt_q[p] - 8'd1;
          icnt_d[p] = dec;
          if (dec == 8'd0) begin
            s = 1'b1; icnt_d[p] = dur_q[p];
          end
        end
        if (pend_q[p]) begin
          s = 1'b1; pend_d[p] = 1'b0; icnt_d[p] = dur_q[p];
        end
        if (s) begin
          if (busy_q[p]) pend_d[p] = 1'b1;
          else begin
            busy_d[p] = 1'b1; send[p] = 1'b1;
          end
        end
      end
      if (send != 2'b00) begin
        res0.kind = KIND_REPORT;
        res0.report_pad = !send[0];
        res0.length = 2'd2;
        res0.data0 = send[0] ? rep_q[0][7:0] : rep_q[1][7:0];
        res0.data1 = send[0] ? rep_q[0][15:8] : rep_q[1][15:8];
        res0.last = 1'b1;
      end
      if (send == 2'b11) begin
        two = 1'b1;
        res0.last = 1'b0;
        res1 = '0;
        res1.kind = KIND_REPORT; res1.report_pad = 1'b1; res1.length = 2'd2;
        res1.data0 = rep_q[1][7:0]; res1.data1 = rep_q[1][15:8];
        res1.last = 1'b1;
      end
    end
  end

  // configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PRESCALE_RST;
      strcnt_q   <= STRING_CNT_RST;
      defidle_q  <= DEFAULT_IDLE_RST;
      sofcnt_q   <= PRESCALE_RST;
      off_q <= '0; pend_q <= '0; busy_q <= '0;
      for (int p = 0; p < NumPads; p++) begin
        dur_q[p] <= DEFAULT_IDLE_RST; icnt_q[p] <= '0; rep_q[p] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SOF_PRESCALE: prescale_q <= cfg_data_i;
          REG_STRING_COUNT: strcnt_q   <= cfg_data_i;
          REG_DEFAULT_IDLE: defidle_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        sofcnt_q <= sofcnt_d;
        off_q <= off_d; pend_q <= pend_d; busy_q <= busy_d;
        dur_q <= dur_d; icnt_q <= icnt_d; rep_q <= rep_d;
      end
    end
  end

  // output register and hold register for a second report; hold feeds output first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      hvalid_q <= 1'b0;
    end else begin
      if (ofree) begin
        if (hvalid_q) begin
          ovalid_q <= 1'b1; odata_q <= hdata_q; hvalid_q <= 1'b0;
        end else if (accept) begin
          ovalid_q <= 1'b1; odata_q <= res0;
          if (two) begin
            hvalid_q <= 1'b1; hdata_q <= res1;
          end
        end else begin
          ovalid_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  property p_hold_needs_out;
    @(posedge clk_i) disable iff (!rst_ni) hvalid_q |-> ovalid_q;
  endproperty
  a_hold_needs_out: assert property (p_hold_needs_out) else $error("hold without output");

  a_no_accept_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hvalid_q |-> !accept) else $error("accept while hold full");

  a_two_reports_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && two) |=> (busy_q == 2'b11)) else $error("two reports without busy");

  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ofree) else $error("accept while output blocked");

endmodule

// ----- src/uhid_setup_dec.sv -----
module uhid_setup_dec (
  input  uhid_pkg::in_word_t   word_i,
  input  logic [7:0]           string_count_i,
  input  logic [15:0]          report_i,
  input  logic [7:0]           duration_i,
  output uhid_pkg::out_word_t  res_o,
  output uhid_pkg::setup_upd_t upd_o
);
  import uhid_pkg::*;

  logic       ifc;
  logic [7:0] rt, il, vh, vl;

  assign rt  = word_i.request_type;
  assign il  = word_i.index_low;
  assign vh  = word_i.value_high;
  assign vl  = word_i.value_low;
  assign ifc = (il == 8'h00) || (il == 8'h01);

  // request decode; report_i and duration_i belong to pad il[0]
  always_comb begin
    res_o = '0;
    res_o.kind = KIND_STALL;
    res_o.last = 1'b1;
    upd_o = '0;
    upd_o.pad = il[0];
    upd_o.duration = vh;
    case (word_i.request)
      RQ_GET_STATUS: begin
        if (rt == 8'h80 || rt == 8'h81 || rt == 8'h82) begin
          res_o.kind = KIND_ACK; res_o.length = 2'd2;
        end
      end
      RQ_CLR_FEATURE, RQ_SET_FEATURE: begin
        if (rt == 8'h00 || rt == 8'h01) begin
          res_o.kind = KIND_ACK;
        end else if (rt == 8'h02) begin
          if (il == 8'h00 || il == 8'h80 || il == 8'h81 || il == 8'h82) begin
            res_o.kind = KIND_ACK;
            res_o.ep_target = (il == 8'h00) ? 2'd0 : (il[1:0] + 2'd1);
            if (word_i.request == RQ_SET_FEATURE) res_o.ep_action = EPA_STALL;
            else if (il[7] && il[1:0] != 2'd0) res_o.ep_action = EPA_UNSTALL;
            else res_o.ep_action = EPA_TOGGLE;
          end
        end else if (rt == RT_CLASS_IN && ifc) begin
          res_o.kind = KIND_ACK;
          if (word_i.request == RQ_SET_FEATURE) begin
            res_o.length = 2'd1; res_o.data0 = 8'd1;
          end else begin
            res_o.length = 2'd2;
            res_o.data0 = report_i[7:0];
            res_o.data1 = report_i[15:8];
            upd_o.clr_pending = 1'b1;
          end
        end
      end
      RQ_GET_IDLE: begin
        if (rt == RT_CLASS_IN && ifc) begin
          res_o.kind = KIND_ACK; res_o.length = 2'd1; res_o.data0 = duration_i;
        end
      end
      RQ_GET_DESC: begin
        if (vh == 8'h01) begin
          res_o.kind = KIND_ACK; res_o.descriptor = DSC_DEVICE;
        end else if (vh == 8'h02) begin
          res_o.kind = KIND_ACK; res_o.descriptor = DSC_CONFIG;
        end else if (vh == 8'h03) begin
          if (vl < string_count_i) begin
            res_o.kind = KIND_ACK; res_o.descriptor = DSC_STRING;
            res_o.str_idx = vl;
          end
        end else if (vh == 8'h21) begin
          res_o.kind = KIND_ACK; res_o.descriptor = DSC_HID;
        end else if (vh == 8'h22 && ifc) begin
          res_o.kind = KIND_ACK; res_o.descriptor = DSC_REPORT;
        end
      end
      RQ_GET_CONFIG: begin
        if (rt == 8'h80) begin
          res_o.kind = KIND_ACK; res_o.length = 2'd1; res_o.data0 = 8'd1;
        end
      end
      RQ_SET_CONFIG: begin
        if (rt == 8'h00) res_o.kind = KIND_ACK;
      end
      RQ_GET_IFACE: begin
        if (rt == 8'h81) begin
          res_o.kind = KIND_ACK; res_o.length = 2'd1;
        end else if (rt == RT_CLASS_OUT && ifc) begin
          res_o.kind = KIND_ACK;
          upd_o.idle_wr = 1'b1;
          upd_o.idle_off = (vh == 8'd0);
        end
      end
      RQ_SET_IFACE: begin
        if (rt == 8'h01) begin
          if (vl == 8'd0 && ifc) begin
            res_o.kind = KIND_ACK; res_o.ep_action = EPA_REARM;
            res_o.ep_target = {1'b1, il[0]};
          end
        end else if (rt == RT_CLASS_OUT) begin
          res_o.kind = KIND_ACK;
        end
      end
      default: ;
    endcase
  end
endmodule
